// ----- rtl/core/fpq_pkg.sv -----
// ============================================================================
// fpq_pkg - shared types and constants of the FIFO priority queue
// Entry layout, operation and status codes, sequencer states and widths.
// ============================================================================
package fpq_pkg;

    localparam int MAX_ENTRIES = 16;
    localparam int IDX_W       = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);

    localparam int KEY_W       = 8;
    localparam int PRIO_W      = 8;
    localparam int OP_W        = 2;
    localparam int STATUS_W    = 2;
    localparam int CAP_W       = 5;
    localparam int COUNT_OUT_W = 5;
    localparam int ENTRY_W     = KEY_W + PRIO_W;
    localparam int CMP_W       = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam int APB_DATA_W = 32;
    localparam int APB_ADDR_W = 3;
    // register index, taken from paddr[2]
    localparam logic REG_CAPACITY = 1'b0;

    typedef enum logic [OP_W-1:0] {
        OP_ENQUEUE     = 2'd0,
        OP_DEQUEUE     = 2'd1,
        OP_DEQUEUE_MAX = 2'd2,
        OP_SEARCH      = 2'd3
    } fpq_op_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK        = 2'd0,
        ST_OVERFLOW  = 2'd1,
        ST_UNDERFLOW = 2'd2,
        ST_NOT_FOUND = 2'd3
    } fpq_status_t;

    typedef enum logic [1:0] {
        FPQ_IDLE  = 2'd0,
        FPQ_SCAN  = 2'd1,
        FPQ_SHIFT = 2'd2
    } fpq_state_t;

    typedef struct packed {
        logic signed [KEY_W-1:0] key;
        logic [PRIO_W-1:0]       prio;
    } fpq_entry_t;

    // control of the shared compare unit
    typedef struct packed {
        logic find_key;   // key equality instead of priority ranking
        logic first;      // first entry of a scan always wins the ranking
    } fpq_cmp_ctl_t;

endpackage

// ----- rtl/core/fpq_ram.sv -----
// ============================================================================
// fpq_ram - generic single-write, single-read RAM
// One write port and one read port; read data is registered.
// ============================================================================
module fpq_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ----- rtl/core/fpq_cmp.sv -----
// ============================================================================
// fpq_cmp - shared compare unit of the queue scanner
// Match a key for search, or rank a priority against the best so far.
// ============================================================================
module fpq_cmp (
    input  fpq_pkg::fpq_cmp_ctl_t              ctl,
    input  fpq_pkg::fpq_entry_t                entry,
    input  logic signed [fpq_pkg::KEY_W-1:0]   ref_key,
    input  logic [fpq_pkg::PRIO_W-1:0]         best_prio,
    output logic                               hit
);

    // strict greater-than keeps the oldest among equal priorities
    always_comb
    begin
        if (ctl.find_key)
        begin
            hit = (entry.key == ref_key);
        end
        else
        begin
            hit = ctl.first || (entry.prio > best_prio);
        end
    end

endmodule

// ----- rtl/core/fifo_priority_queue_unit.sv -----
// ============================================================================
// fifo_priority_queue_unit - bounded queue with FIFO order and priority take
// Entries sit in arrival order in a RAM; a sequencer scans them through one
// compare unit and closes gaps by moving entries down one slot per cycle.
// ============================================================================
//
//  channel   handshake                       payload
//  --------  ------------------------------  ----------------------------------
//  command   start (taken when busy is low)  operation, item_key, item_priority
//  result    done, one-cycle strobe          out_key, status, entry_count
//  config    APB write (psel/penable/pwrite) paddr, pwdata; prdata on read
//
//  Timing: an enqueue and any operation on an empty queue transfer their result
//  in the cycle after the command. A search, a dequeue of the oldest and a dequeue
//  of the highest priority scan entries through the RAM's single read port, one
//  entry a cycle; the two dequeues then move later entries down one slot.
//  Reset: rst_n clears the queue to empty and capacity to 16; RAM contents are
//  left as they are and only slots below the count are ever read.
//  Stalls: none; the result is shown for one cycle and the receiver takes it.
//  A new command may be given in the cycle the previous result is shown.
// ============================================================================
module fifo_priority_queue_unit (
    input  logic                                   clk,
    input  logic                                   rst_n,
    // command
    input  logic                                   start,
    output logic                                   busy,
    input  logic [fpq_pkg::OP_W-1:0]               operation,
    input  logic signed [fpq_pkg::KEY_W-1:0]       item_key,
    input  logic [fpq_pkg::PRIO_W-1:0]             item_priority,
    // result
    output logic                                   done,
    output logic signed [fpq_pkg::KEY_W-1:0]       out_key,
    output logic [fpq_pkg::STATUS_W-1:0]           status,
    output logic [fpq_pkg::COUNT_OUT_W-1:0]        entry_count,
    // configuration
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic [fpq_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [fpq_pkg::APB_DATA_W-1:0]         pwdata,
    output logic [fpq_pkg::APB_DATA_W-1:0]         prdata,
    output logic                                   pready
);

    localparam int CNT_W  = fpq_pkg::CNT_W;
    localparam int IDX_W  = fpq_pkg::IDX_W;
    localparam int CMP_W  = fpq_pkg::CMP_W;
    localparam int COUT_W = fpq_pkg::COUNT_OUT_W;

    // ---------------------------------------------------------------- control
    fpq_pkg::fpq_state_t    state_reg,  state_next;
    logic [CNT_W-1:0]       count_reg,  count_next;
    logic [fpq_pkg::CAP_W-1:0] cap_reg;
    logic                   rvalid_reg, rvalid_next;
    logic                   done_reg,   done_next;

    // ---------------------------------------------------------------- payload
    fpq_pkg::fpq_op_t                    op_reg,        op_next;
    logic signed [fpq_pkg::KEY_W-1:0]    key_reg,       key_next;
    logic [CNT_W-1:0]                    rd_idx_reg,    rd_idx_next;
    logic [CNT_W-1:0]                    ridx_reg,      ridx_next;
    logic [CNT_W-1:0]                    limit_reg,     limit_next;
    logic [CNT_W-1:0]                    best_idx_reg,  best_idx_next;
    logic [fpq_pkg::PRIO_W-1:0]          best_prio_reg, best_prio_next;
    logic signed [fpq_pkg::KEY_W-1:0]    best_key_reg,  best_key_next;
    logic                                found_reg,     found_next;
    logic signed [fpq_pkg::KEY_W-1:0]    out_key_reg,   out_key_next;
    fpq_pkg::fpq_status_t                status_reg,    status_next;
    logic [COUT_W-1:0]                   cnt_out_reg,   cnt_out_next;

    // ------------------------------------------------------------ datapath
    fpq_pkg::fpq_op_t       op_in;
    fpq_pkg::fpq_entry_t    ram_wdata;
    fpq_pkg::fpq_entry_t    ram_rdata;
    logic                   ram_we;
    logic [IDX_W-1:0]       ram_waddr;
    logic [IDX_W-1:0]       ram_raddr;
    fpq_pkg::fpq_cmp_ctl_t  cmp_ctl;
    logic                   cmp_hit;
    logic                   queue_full;
    logic [CNT_W-1:0]       count_inc;
    logic [CNT_W-1:0]       count_dec;
    logic [CNT_W-1:0]       move_dst;
    logic                   cfg_write;

    assign op_in     = fpq_pkg::fpq_op_t'(operation);
    assign count_inc = count_reg + 1'b1;
    assign count_dec = count_reg - 1'b1;
    // the entry read from slot ridx moves down to slot ridx-1
    assign move_dst  = ridx_reg - 1'b1;

    // refuse when the count reaches the programmed capacity or the storage size
    assign queue_full = (CMP_W'(count_reg) >= CMP_W'(cap_reg))
                     || (count_reg >= CNT_W'(fpq_pkg::MAX_ENTRIES));

    // ------------------------------------------------------- entry storage
    fpq_ram #(
        .WIDTH (fpq_pkg::ENTRY_W),
        .DEPTH (fpq_pkg::MAX_ENTRIES)
    ) u_entries (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // ---------------------------------------------------- shared compare unit
    assign cmp_ctl.find_key = (op_reg == fpq_pkg::OP_SEARCH);
    assign cmp_ctl.first    = (ridx_reg == '0);

    fpq_cmp u_cmp (
        .ctl       (cmp_ctl),
        .entry     (ram_rdata),
        .ref_key   (key_reg),
        .best_prio (best_prio_reg),
        .hit       (cmp_hit)
    );

    // ------------------------------------------------------ configuration port
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign prdata    = (paddr[2] == fpq_pkg::REG_CAPACITY)
                     ? fpq_pkg::APB_DATA_W'(cap_reg) : '0;

    // ------------------------------------------------------------- sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= fpq_pkg::FPQ_IDLE;
            count_reg  <= '0;
            cap_reg    <= fpq_pkg::CAP_RESET;
            rvalid_reg <= 1'b0;
            done_reg   <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            rvalid_reg <= rvalid_next;
            done_reg   <= done_next;
            if (cfg_write && (paddr[2] == fpq_pkg::REG_CAPACITY))
            begin
                cap_reg <= pwdata[fpq_pkg::CAP_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg        <= op_next;
        key_reg       <= key_next;
        rd_idx_reg    <= rd_idx_next;
        ridx_reg      <= ridx_next;
        limit_reg     <= limit_next;
        best_idx_reg  <= best_idx_next;
        best_prio_reg <= best_prio_next;
        best_key_reg  <= best_key_next;
        found_reg     <= found_next;
        out_key_reg   <= out_key_next;
        status_reg    <= status_next;
        cnt_out_reg   <= cnt_out_next;
    end

    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg;
        rvalid_next    = 1'b0;
        done_next      = 1'b0;
        op_next        = op_reg;
        key_next       = key_reg;
        rd_idx_next    = rd_idx_reg;
        ridx_next      = ridx_reg;
        limit_next     = limit_reg;
        best_idx_next  = best_idx_reg;
        best_prio_next = best_prio_reg;
        best_key_next  = best_key_reg;
        found_next     = found_reg;
        out_key_next   = out_key_reg;
        status_next    = status_reg;
        cnt_out_next   = cnt_out_reg;
        ram_we         = 1'b0;
        ram_waddr      = count_reg[IDX_W-1:0];
        ram_wdata      = '{key: item_key, prio: item_priority};
        ram_raddr      = rd_idx_reg[IDX_W-1:0];

        case (state_reg)
            fpq_pkg::FPQ_IDLE:
            begin
                if (start)
                begin
                    op_next       = op_in;
                    key_next      = item_key;
                    rd_idx_next   = '0;
                    best_idx_next = '0;
                    found_next    = 1'b0;
                    if (op_in == fpq_pkg::OP_ENQUEUE)
                    begin
                        // append at the tail, or refuse and leave the queue alone
                        done_next    = 1'b1;
                        out_key_next = '0;
                        if (queue_full)
                        begin
                            status_next  = fpq_pkg::ST_OVERFLOW;
                            cnt_out_next = COUT_W'(count_reg);
                        end
                        else
                        begin
                            ram_we       = 1'b1;
                            count_next   = count_inc;
                            status_next  = fpq_pkg::ST_OK;
                            cnt_out_next = COUT_W'(count_inc);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        done_next    = 1'b1;
                        out_key_next = '0;
                        cnt_out_next = COUT_W'(count_reg);
                        status_next  = (op_in == fpq_pkg::OP_SEARCH)
                                     ? fpq_pkg::ST_NOT_FOUND : fpq_pkg::ST_UNDERFLOW;
                    end
                    else
                    begin
                        // dequeue of the oldest is a scan of slot 0 alone
                        limit_next = (op_in == fpq_pkg::OP_DEQUEUE)
                                   ? CNT_W'(1) : count_reg;
                        state_next = fpq_pkg::FPQ_SCAN;
                    end
                end
            end

            fpq_pkg::FPQ_SCAN:
            begin
                // issue one read a cycle; the registered data returns in the following cycle
                if (rd_idx_reg < limit_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = rd_idx_reg;
                end
                if (rvalid_reg && cmp_hit)
                begin
                    if (op_reg == fpq_pkg::OP_SEARCH)
                    begin
                        found_next = 1'b1;
                    end
                    else
                    begin
                        best_idx_next  = ridx_reg;
                        best_prio_next = ram_rdata.prio;
                        best_key_next  = ram_rdata.key;
                    end
                end
                if ((rd_idx_reg == limit_reg) && !rvalid_reg)
                begin
                    if (op_reg == fpq_pkg::OP_SEARCH)
                    begin
                        done_next    = 1'b1;
                        out_key_next = '0;
                        cnt_out_next = COUT_W'(count_reg);
                        status_next  = found_reg ? fpq_pkg::ST_OK : fpq_pkg::ST_NOT_FOUND;
                        state_next   = fpq_pkg::FPQ_IDLE;
                    end
                    else
                    begin
                        // close the gap: move every later entry down one slot
                        rd_idx_next = best_idx_reg + 1'b1;
                        state_next  = fpq_pkg::FPQ_SHIFT;
                    end
                end
            end

            fpq_pkg::FPQ_SHIFT:
            begin
                if (rd_idx_reg < count_reg)
                begin
                    rd_idx_next = rd_idx_reg + 1'b1;
                    rvalid_next = 1'b1;
                    ridx_next   = rd_idx_reg;
                end
                if (rvalid_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = move_dst[IDX_W-1:0];
                    ram_wdata = ram_rdata;
                end
                if ((rd_idx_reg == count_reg) && !rvalid_reg)
                begin
                    count_next   = count_dec;
                    done_next    = 1'b1;
                    out_key_next = best_key_reg;
                    status_next  = fpq_pkg::ST_OK;
                    cnt_out_next = COUT_W'(count_dec);
                    state_next   = fpq_pkg::FPQ_IDLE;
                end
            end

            default:
            begin
                state_next = fpq_pkg::FPQ_IDLE;
            end
        endcase
    end

    // ---------------------------------------------------------------- outputs
    assign busy        = (state_reg != fpq_pkg::FPQ_IDLE);
    assign done        = done_reg;
    assign out_key     = out_key_reg;
    assign status      = status_reg;
    assign entry_count = cnt_out_reg;

    // ------------------------------------------------------------- assertions
    // a result is only shown once the sequencer is back to idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while sequencer busy");

    // an enqueue result is always shown in the cycle after the command
    a_enq_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation == fpq_pkg::OP_ENQUEUE)) |=> done)
        else $error("enqueue did not finish in one cycle");

    // any other command on an empty queue answers at once with an empty status
    a_empty_fast: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy && (operation != fpq_pkg::OP_ENQUEUE) && (count_reg == '0))
        |=> (done && ((status == fpq_pkg::ST_UNDERFLOW)
                   || (status == fpq_pkg::ST_NOT_FOUND))))
        else $error("empty queue did not answer at once");

    // a refused enqueue leaves the count alone
    a_overflow_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (done && (status == fpq_pkg::ST_OVERFLOW)) |-> (count_reg == $past(count_reg)))
        else $error("refused enqueue changed the count");

    // the count never exceeds the storage while the sequencer is busy
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        busy |-> (count_reg <= CNT_W'(fpq_pkg::MAX_ENTRIES)))
        else $error("entry count beyond storage");

endmodule

// ----- tb/sv/fifo_priority_queue_unit_checker.sv -----
// ============================================================================
// fifo_priority_queue_unit_checker - outcome predictor and result comparator
// Watches the command, result and APB channels of the FIFO priority queue,
// keeps its own copy of the queue and capacity, and compares every result.
// ============================================================================
module fifo_priority_queue_unit_checker (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  logic                                   start,
    input  logic                                   busy,
    input  logic [fpq_pkg::OP_W-1:0]               operation,
    input  logic signed [fpq_pkg::KEY_W-1:0]       item_key,
    input  logic [fpq_pkg::PRIO_W-1:0]             item_priority,
    input  logic                                   done,
    input  logic signed [fpq_pkg::KEY_W-1:0]       out_key,
    input  logic [fpq_pkg::STATUS_W-1:0]           status,
    input  logic [fpq_pkg::COUNT_OUT_W-1:0]        entry_count,
    input  logic                                   psel,
    input  logic                                   penable,
    input  logic                                   pwrite,
    input  logic                                   pready,
    input  logic [fpq_pkg::APB_ADDR_W-1:0]         paddr,
    input  logic [fpq_pkg::APB_DATA_W-1:0]         pwdata,
    output int                                     mismatch_count,
    output int                                     outcomes_outstanding
);
    import fpq_pkg::*;

    typedef struct {
        logic signed [KEY_W-1:0]   key;
        fpq_status_t               code;
        logic [COUNT_OUT_W-1:0]    count;
    } queue_outcome_t;

    logic signed [KEY_W-1:0] held_keys [MAX_ENTRIES];
    logic [PRIO_W-1:0]       held_prios [MAX_ENTRIES];
    int                      held;
    logic [CAP_W-1:0]        capacity_reg;
    queue_outcome_t          outcomes_due [$];

    // remove one slot and close the gap, oldest entries stay in front
    function automatic logic signed [KEY_W-1:0] take_slot(int pos);
        logic signed [KEY_W-1:0] k;
        k = held_keys[pos];
        for (int i = pos; i + 1 < held; i++)
        begin
            held_keys[i]  = held_keys[i + 1];
            held_prios[i] = held_prios[i + 1];
        end
        held--;
        return k;
    endfunction

    function automatic queue_outcome_t perform_queue_op(fpq_op_t op,
                                                        logic signed [KEY_W-1:0] k,
                                                        logic [PRIO_W-1:0] p);
        queue_outcome_t r;
        int             limit;
        int             best;
        r.key  = '0;
        r.code = ST_OK;
        limit  = (capacity_reg > MAX_ENTRIES) ? MAX_ENTRIES : int'(capacity_reg);
        case (op)
            OP_ENQUEUE:
            begin
                if (held >= limit)
                    r.code = ST_OVERFLOW;
                else
                begin
                    held_keys[held]  = k;
                    held_prios[held] = p;
                    held++;
                end
            end
            OP_DEQUEUE:
            begin
                if (held == 0)
                    r.code = ST_UNDERFLOW;
                else
                    r.key = take_slot(0);
            end
            OP_DEQUEUE_MAX:
            begin
                if (held == 0)
                    r.code = ST_UNDERFLOW;
                else
                begin
                    best = 0;
                    for (int i = 1; i < held; i++)
                        if (held_prios[i] > held_prios[best])
                            best = i;
                    r.key = take_slot(best);
                end
            end
            default:
            begin
                r.code = ST_NOT_FOUND;
                for (int i = 0; i < held; i++)
                    if (held_keys[i] == k)
                        r.code = ST_OK;
            end
        endcase
        r.count = COUNT_OUT_W'(held);
        return r;
    endfunction

    initial
    begin
        mismatch_count       = 0;
        outcomes_outstanding = 0;
        held                 = 0;
        capacity_reg         = CAP_RESET;
    end

    always @(posedge clk)
    begin
        queue_outcome_t due;
        if (!rst_n)
        begin
            held         = 0;
            capacity_reg = CAP_RESET;
            outcomes_due.delete();
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr[2] == REG_CAPACITY)
                capacity_reg = pwdata[CAP_W-1:0];
            // check the result of an earlier command before taking a new one
            if (done)
            begin
                if (outcomes_due.size() == 0)
                begin
                    $error("result with no command outstanding: out_key %0d status %0d",
                           out_key, status);
                    mismatch_count++;
                end
                else
                begin
                    due = outcomes_due.pop_front();
                    if (out_key !== due.key)
                    begin
                        $error("out_key: expected %0d, got %0d", due.key, out_key);
                        mismatch_count++;
                    end
                    if (status !== due.code)
                    begin
                        $error("status: expected %0d, got %0d", due.code, status);
                        mismatch_count++;
                    end
                    if (entry_count !== due.count)
                    begin
                        $error("entry_count: expected %0d, got %0d", due.count, entry_count);
                        mismatch_count++;
                    end
                end
            end
            if (start && !busy)
                outcomes_due.push_back(perform_queue_op(fpq_op_t'(operation),
                                                        item_key, item_priority));
        end
        outcomes_outstanding = outcomes_due.size();
    end

endmodule

// ----- tb/sv/fifo_priority_queue_unit_test.sv -----
// ============================================================================
// fifo_priority_queue_unit_test - stimulus and verdict for the FIFO priority queue
// Runs a directed sequence over the empty, tie and extreme-value cases, then
// random phases under different capacities, most with random gaps between commands.
// ============================================================================
module fifo_priority_queue_unit_test;
    import fpq_pkg::*;

    logic                      clk;
    logic                      rst_n;
    logic                      start;
    logic                      busy;
    logic [OP_W-1:0]           operation;
    logic signed [KEY_W-1:0]   item_key;
    logic [PRIO_W-1:0]         item_priority;
    logic                      done;
    logic signed [KEY_W-1:0]   out_key;
    logic [STATUS_W-1:0]       status;
    logic [COUNT_OUT_W-1:0]    entry_count;
    logic                      psel;
    logic                      penable;
    logic                      pwrite;
    logic [APB_ADDR_W-1:0]     paddr;
    logic [APB_DATA_W-1:0]     pwdata;
    logic [APB_DATA_W-1:0]     prdata;
    logic                      pready;

    int                        mismatch_count;
    int                        outcomes_outstanding;
    bit                        gaps_enabled;

    fifo_priority_queue_unit u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .start         (start),
        .busy          (busy),
        .operation     (operation),
        .item_key      (item_key),
        .item_priority (item_priority),
        .done          (done),
        .out_key       (out_key),
        .status        (status),
        .entry_count   (entry_count),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    fifo_priority_queue_unit_checker u_checker (
        .clk                  (clk),
        .rst_n                (rst_n),
        .start                (start),
        .busy                 (busy),
        .operation            (operation),
        .item_key             (item_key),
        .item_priority        (item_priority),
        .done                 (done),
        .out_key              (out_key),
        .status               (status),
        .entry_count          (entry_count),
        .psel                 (psel),
        .penable              (penable),
        .pwrite               (pwrite),
        .pready               (pready),
        .paddr                (paddr),
        .pwdata               (pwdata),
        .mismatch_count       (mismatch_count),
        .outcomes_outstanding (outcomes_outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // Issue one command transfer. Called at a falling edge, returns at the
    // falling edge after the transfer. With no gap, start stays high so
    // back-to-back commands go out without a bubble.
    task automatic send_command(input fpq_op_t op, input logic signed [KEY_W-1:0] k,
                                input logic [PRIO_W-1:0] p);
        int gap;
        gap = gaps_enabled ? $urandom_range(0, 13) : 0;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start         <= 1'b1;
        operation     <= op;
        item_key      <= k;
        item_priority <= p;
        // hold the command until busy is low at a rising edge
        do
            @(posedge clk);
        while (busy);
        @(negedge clk);
    endtask

    // Wait for the queue to go quiet, then write the capacity register with
    // random upper bits; only the low five bits are meaningful.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        start <= 1'b0;
        while (outcomes_outstanding != 0)
            @(negedge clk);
        repeat (4) @(negedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {REG_CAPACITY, 2'b00};
        pwdata  <= {27'($urandom), cap};
        @(negedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Keys lean toward a few values so searches hit as well as miss.
    function automatic logic signed [KEY_W-1:0] pick_key();
        case ($urandom_range(0, 5))
            0:       return -8'sd128;
            1:       return 8'sd127;
            2, 3:    return KEY_W'($urandom_range(0, 3)) - 8'sd2;
            default: return KEY_W'($urandom);
        endcase
    endfunction

    // Priorities lean toward a narrow range so ties are common.
    function automatic logic [PRIO_W-1:0] pick_priority();
        case ($urandom_range(0, 3))
            0, 1:    return PRIO_W'($urandom_range(0, 3));
            2:       return PRIO_W'($urandom);
            default: return ($urandom_range(0, 1) != 0) ? 8'd255 : 8'd0;
        endcase
    endfunction

    // mode 0 fills the queue, mode 1 mixes, mode 2 drains
    function automatic fpq_op_t pick_op(int mode);
        int roll;
        int enq_cut;
        roll    = $urandom_range(0, 99);
        enq_cut = (mode == 0) ? 60 : (mode == 1) ? 38 : 20;
        if (roll < enq_cut)
            return OP_ENQUEUE;
        else if (roll < enq_cut + (100 - enq_cut) / 3)
            return OP_DEQUEUE;
        else if (roll < enq_cut + 2 * (100 - enq_cut) / 3)
            return OP_DEQUEUE_MAX;
        else
            return OP_SEARCH;
    endfunction

    initial
    begin
        // capacity per phase: fill at full size, then lower below the count,
        // block every enqueue, saturate above the queue size, and so on
        logic [CAP_W-1:0] phase_caps [12];
        int               phase_modes [12];
        phase_caps  = '{5'd16, 5'd4, 5'd0, 5'd31, 5'd1, 5'd17,
                        5'd2, 5'd16, 5'd9, 5'd0, 5'd16, 5'd5};
        phase_modes = '{0, 1, 2, 0, 1, 0, 1, 0, 1, 2, 1, 2};

        rst_n         = 1'b0;
        start         = 1'b0;
        operation     = OP_ENQUEUE;
        item_key      = '0;
        item_priority = '0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        gaps_enabled  = 1'b1;
        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // empty queue: both dequeues underflow, search misses
        send_command(OP_DEQUEUE, 8'sd0, 8'd0);
        send_command(OP_DEQUEUE_MAX, 8'sd0, 8'd0);
        send_command(OP_SEARCH, 8'sd0, 8'd0);
        // extremes of key and priority, with a tie at the top priority
        send_command(OP_ENQUEUE, -8'sd128, 8'd0);
        send_command(OP_ENQUEUE, 8'sd127, 8'd255);
        send_command(OP_ENQUEUE, 8'sd0, 8'd255);
        send_command(OP_ENQUEUE, -8'sd1, 8'd128);
        send_command(OP_SEARCH, 8'sd127, 8'd0);
        send_command(OP_SEARCH, -8'sd128, 8'd0);
        send_command(OP_SEARCH, 8'sd1, 8'd0);
        // the oldest of the two top-priority entries leaves first
        send_command(OP_DEQUEUE_MAX, 8'sd0, 8'd0);
        send_command(OP_DEQUEUE_MAX, 8'sd0, 8'd0);
        send_command(OP_DEQUEUE, 8'sd0, 8'd0);
        send_command(OP_DEQUEUE, 8'sd0, 8'd0);
        send_command(OP_DEQUEUE, 8'sd0, 8'd0);
        // alternating bit patterns in key and priority
        send_command(OP_ENQUEUE, 8'sh55, 8'haa);
        send_command(OP_ENQUEUE, -8'sd86, 8'h55);
        send_command(OP_SEARCH, -8'sd86, 8'd0);
        send_command(OP_DEQUEUE_MAX, 8'sd0, 8'd0);
        send_command(OP_DEQUEUE, 8'sd0, 8'd0);

        // random phases; the queue carries over from one phase to the next
        for (int ph = 0; ph < 12; ph++)
        begin
            write_capacity(phase_caps[ph]);
            // some phases run with no gaps between commands
            gaps_enabled = (ph % 4) != 2;
            for (int n = 0; n < 62; n++)
                send_command(pick_op(phase_modes[ph]), pick_key(), pick_priority());
        end
        start <= 1'b0;

        // drain: let the last result arrive, then idle for a full scan time
        while (outcomes_outstanding != 0)
            @(negedge clk);
        repeat (2 * MAX_ENTRIES + 8) @(negedge clk);

        if (mismatch_count == 0 && outcomes_outstanding == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

    // watchdog: far beyond the slowest legal run
    initial
    begin
        #2000000;
        $display("Verification failed");
        $finish;
    end

endmodule

// ----- filelist.f -----
rtl/core/fpq_pkg.sv
rtl/core/fpq_ram.sv
rtl/core/fpq_cmp.sv
rtl/core/fifo_priority_queue_unit.sv
tb/sv/fifo_priority_queue_unit_checker.sv
tb/sv/fifo_priority_queue_unit_test.sv
